/* src/ipv4hb_pkg.sv */
// ----------------------------------------------------------------------------
// ipv4hb_pkg
// Shared types and constants for the IPv4 header builder.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4hb_pkg;

	// Header length limits, in 32-bit words
	localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
	// Words 0..9 are the fixed header; higher words are zero options
	localparam int         FIXED_WORDS   = 10;
	localparam int         IDX_W         = 5;
	localparam int         IN_DATA_W     = 144;
	localparam int         OUT_DATA_W    = 24;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_HLEN = 2'd1,
		ST_SHORT    = 2'd2
	} status_t;

	// One set of header fields as taken in
	typedef struct packed {
		logic [31:0] destination_address;
		logic [31:0] source_address;
		logic [7:0]  protocol_number;
		logic [7:0]  time_to_live;
		logic [12:0] fragment_offset;
		logic [2:0]  frag_flags;
		logic [15:0] identifier;
		logic [15:0] total_length;
		logic [7:0]  type_of_service;
		logic [3:0]  header_words;
		logic [3:0]  version;
	} hdr_t;

	// Built header handed to the emitter
	typedef struct packed {
		logic [FIXED_WORDS-1:0][15:0] words;
		logic [IDX_W-1:0]             count;
		status_t                      status;
	} frame_t;

endpackage

`default_nettype wire

/* src/ipv4hb_in_reg.sv */
// ----------------------------------------------------------------------------
// ipv4hb_in_reg
// Input register: holds one accepted set of header fields until the
// emitter loads it.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hb_in_reg (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       s_tvalid,
	output logic                      s_tready,
	input  wire  [143:0]              s_tdata,
	input  wire                       take,
	output logic                      valid_s1,
	output ipv4hb_pkg::hdr_t          hdr_s1
);
	import ipv4hb_pkg::*;

	// Free when empty, or when the held item moves on this cycle
	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Payload register, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			hdr_s1 <= hdr_t'(s_tdata);
		end
	end

endmodule

`default_nettype wire

/* src/ipv4hb_build.sv */
// ----------------------------------------------------------------------------
// ipv4hb_build
// Forms the ten fixed header words, checks the lengths and inserts the
// folded one's-complement header checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hb_build (
	input  ipv4hb_pkg::hdr_t   hdr,
	output ipv4hb_pkg::frame_t frame
);
	import ipv4hb_pkg::*;

	logic [FIXED_WORDS-1:0][15:0] w;
	logic [19:0]                  sum;
	logic [16:0]                  fold1;
	logic [16:0]                  fold2;
	logic [5:0]                   hdr_bytes;

	// Raw header words, checksum slot zero
	always_comb begin
		w[0] = {hdr.version, hdr.header_words, hdr.type_of_service};
		w[1] = hdr.total_length;
		w[2] = hdr.identifier;
		w[3] = {hdr.frag_flags, hdr.fragment_offset};
		w[4] = {hdr.time_to_live, hdr.protocol_number};
		w[5] = 16'h0000;
		w[6] = hdr.source_address[31:16];
		w[7] = hdr.source_address[15:0];
		w[8] = hdr.destination_address[31:16];
		w[9] = hdr.destination_address[15:0];
	end

	// Sum of ten words fits in 20 bits; fold twice and invert
	always_comb begin
		sum = '0;
		for (int i = 0; i < FIXED_WORDS; i++) begin
			sum = sum + {4'd0, w[i]};
		end
		fold1 = {13'd0, sum[19:16]} + {1'b0, sum[15:0]};
		fold2 = {16'd0, fold1[16]} + {1'b0, fold1[15:0]};
	end

	assign hdr_bytes = {hdr.header_words, 2'b00};

	// Length checks, header length first
	always_comb begin
		frame.words    = w;
		frame.words[5] = ~fold2[15:0];
		frame.count    = {hdr.header_words, 1'b0};
		frame.status   = ST_OK;
		if (hdr.header_words < MIN_HDR_WORDS) begin
			frame.status = ST_BAD_HLEN;
			frame.count  = IDX_W'(1);
		end else if (hdr.total_length < {10'd0, hdr_bytes}) begin
			frame.status = ST_SHORT;
			frame.count  = IDX_W'(1);
		end
	end

endmodule

`default_nettype wire

/* src/ipv4hb_emit.sv */
// ----------------------------------------------------------------------------
// ipv4hb_emit
// Latches a built header and sends it out one 16-bit word per beat,
// zero for option words, with tlast on the final word.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hb_emit (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 load_req,
	input  ipv4hb_pkg::frame_t  frame,
	output logic                take,
	output logic                m_tvalid,
	input  wire                 m_tready,
	output logic [23:0]         m_tdata,
	output logic                m_tlast,
	output logic [1:0]          m_tuser
);
	import ipv4hb_pkg::*;

	logic [FIXED_WORDS-1:0][15:0] words_q;
	logic [IDX_W-1:0]             cnt_q;
	logic [IDX_W-1:0]             n_q;
	status_t                      status_q;
	logic                         busy_q;
	logic                         last;
	logic                         beat;
	logic [15:0]                  word;

	assign last = (cnt_q + IDX_W'(1)) == n_q;
	assign beat = busy_q && m_tready;
	// Load when idle or when the final beat goes out this cycle
	assign take = load_req && (!busy_q || (beat && last));

	// Control: counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			n_q    <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			n_q    <= frame.count;
		end else if (beat) begin
			if (last) begin
				busy_q <= 1'b0;
				cnt_q  <= '0;
			end else begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
		end
	end

	// Latched header words
	always_ff @(posedge clk) begin
		if (take) begin
			words_q  <= frame.words;
			status_q <= frame.status;
		end
	end

	// Word select; error results and option words are zero
	always_comb begin
		word = 16'h0000;
		if (status_q == ST_OK && cnt_q < IDX_W'(FIXED_WORDS)) begin
			word = words_q[cnt_q[3:0]];
		end
	end

	assign m_tvalid = busy_q;
	assign m_tdata  = {3'b000, cnt_q, word};
	assign m_tlast  = last;
	assign m_tuser  = status_q;

endmodule

`default_nettype wire

/* src/ipv4_header_builder_unit.sv */
// ----------------------------------------------------------------------------
// ipv4_header_builder_unit
// IPv4 header generator with Internet header checksum.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one beat carries a full set of header fields. The block
//   answers with 2 * header_words master beats of 16-bit header words in
//   network order, word 5 holding the inverted one's-complement checksum,
//   option words zero, tlast on the final word and tuser = status (0).
//   A header length below 5, or a total length below 4 * header_words,
//   gives one beat with data zero, tlast set and tuser = 1 or 2.
//   The emitter sends one word per beat, or one zero beat for an error
//   result, and holds while m_tready is low. The next input beat is
//   taken while a header is still going out and is loaded on the cycle
//   its final word leaves.
//   Reset clears the input valid flag and emitter state; no output is valid.
//   A stalled master side holds the current word; the slave side then
//   stops after one waiting item.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_header_builder_unit (
	input  wire          clk,
	input  wire          arst_n,
	// tdata: version, header_words, type_of_service, total_length,
	// identifier, frag_flags, fragment_offset, time_to_live,
	// protocol_number, source_address, destination_address
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [143:0] s_tdata,
	// tdata: header_word[15:0], word_index[20:16], zero fill
	// tlast: last_word; tuser: status
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [23:0]  m_tdata,
	output logic         m_tlast,
	output logic [1:0]   m_tuser
);
	import ipv4hb_pkg::*;

	logic   valid_s1;
	logic   take;
	hdr_t   hdr_s1;
	frame_t frame;

	ipv4hb_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.take     (take),
		.valid_s1 (valid_s1),
		.hdr_s1   (hdr_s1)
	);

	ipv4hb_build u_build (
		.hdr   (hdr_s1),
		.frame (frame)
	);

	ipv4hb_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load_req (valid_s1),
		.frame    (frame),
		.take     (take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

/* src/ipv4hb_chk.sv */
// ----------------------------------------------------------------------------
// ipv4hb_chk
// Port-level checks on the header builder's output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hb_chk (
	input wire         clk,
	input wire         arst_n,
	input wire         m_tvalid,
	input wire         m_tready,
	input wire [23:0]  m_tdata,
	input wire         m_tlast,
	input wire [1:0]   m_tuser
);

	// Stalled beat holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output beat changed");

	// Words of a header follow each other without gaps
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && m_tdata[20:16] == $past(m_tdata[20:16]) + 5'd1)
		else $error("word index did not advance");

	// Error results are a single zero beat
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != 2'd0 |-> m_tlast && m_tdata == 24'd0)
		else $error("bad error result");

	// A good header ends on an odd word index
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && m_tuser == 2'd0 |->
			m_tdata[16] && m_tdata[20:16] >= 5'd9)
		else $error("bad header word count");

endmodule

bind ipv4_header_builder_unit ipv4hb_chk u_chk (.*);

`default_nettype wire
